// ===== rtl/bvs_pkg.sv =====
// Shared widths, reset values, register indexes and divider handshake types
// for the battery voltage smoother. No dependencies.
`default_nettype none

package bvs_pkg;

  localparam int RAW_W       = 12;
  localparam int SCALE_W     = 20;
  localparam int SCALE_SHIFT = 16;
  localparam int TICK_W      = 24;
  localparam int MV_W        = 13;
  localparam int PCT_W       = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int WINDOW_LENGTH_DEF = 8;

  localparam logic [SCALE_W-1:0] MV_SCALE_RST   = 20'd105600;
  localparam logic [TICK_W-1:0]  INTERVAL_RST   = 24'd1000;
  localparam logic [MV_W-1:0]    VALID_LOW_RST  = 13'd2500;
  localparam logic [MV_W-1:0]    VALID_HIGH_RST = 13'd5000;
  localparam logic [MV_W-1:0]    EMPTY_RST      = 13'd3200;
  localparam logic [MV_W-1:0]    FULL_RST       = 13'd4200;

  localparam logic [PCT_W-1:0]   PCT_FULL       = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MV_SCALE   = 3'd0,
    CFG_INTERVAL   = 3'd1,
    CFG_VALID_LOW  = 3'd2,
    CFG_VALID_HIGH = 3'd3,
    CFG_EMPTY      = 3'd4,
    CFG_FULL       = 3'd5
  } cfg_idx_t;

  // Quotient bit count for the percentage division on the divider
  localparam int DIV_QCNT_W = 4;
  localparam logic [DIV_QCNT_W-1:0] QBITS_PCT = 4'd7;

  typedef struct packed {
    logic                  start;
    logic [DIV_QCNT_W-1:0] qbits;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [MV_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bvs_if.sv =====
// Valid/ready channel interfaces for the sample, result and config ports.
// Depends on bvs_pkg for payload widths.
`default_nettype none

interface bvs_in_if;
  import bvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sample;
  logic             force_update;

  modport source (output valid, output raw_sample, output force_update, input ready);
  modport sink   (input valid, input raw_sample, input force_update, output ready);
endinterface

interface bvs_out_if;
  import bvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [MV_W-1:0]  smoothed_mv;
  logic [PCT_W-1:0] charge_percent;
  logic             updated;
  logic             sample_valid;

  modport source (output valid, output smoothed_mv, output charge_percent,
                  output updated, output sample_valid, input ready);
  modport sink   (input valid, input smoothed_mv, input charge_percent,
                  input updated, input sample_valid, output ready);
endinterface

interface bvs_cfg_if;
  import bvs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/battery_voltage_smoother_unit.sv =====
// Battery voltage smoother, one item in flight. The time from the input accept to the load of the
// result register is set by the ring walk (one read port) and the one-bit-per-cycle percentage
// divider; a tick without an update skips the walk, a clamped percentage skips the divider, and
// the first update also fills the whole ring. The next beat is taken in the cycle after the result
// loads, and a stalled result holds the block. Reset (rst_n low, synchronous) loads the defaults.
`default_nettype none

module battery_voltage_smoother_unit #(
  parameter int WINDOW_LENGTH = bvs_pkg::WINDOW_LENGTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bvs_in_if.sink    in_chan,
  bvs_out_if.source out_chan,
  bvs_cfg_if.sink   cfg_chan
);
  import bvs_pkg::*;

  localparam int SLOT_W  = $clog2(WINDOW_LENGTH);
  localparam int AGE_W   = $clog2(WINDOW_LENGTH + 1);
  localparam int WT_W    = $clog2(2 * WINDOW_LENGTH);
  localparam int SUM_W   = SLOT_W + 2;
  localparam int TOTAL   = WINDOW_LENGTH * (3 * WINDOW_LENGTH - 1) / 2;
  localparam int TOT_W   = $clog2(TOTAL + 1);
  localparam int ACC_W   = MV_W + TOT_W;
  localparam int DVS_W   = (TOT_W > MV_W) ? TOT_W : MV_W;
  localparam int DVD_W   = (ACC_W > DVS_W + MV_W) ? ACC_W : DVS_W + MV_W;
  localparam int MA_W    = (ACC_W > SCALE_W) ? ACC_W : SCALE_W;
  localparam int MB_W    = MV_W + 2;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int MVF_W   = RAW_W + SCALE_W - SCALE_SHIFT;

  // Reciprocal of the total weight, scaled by 2^ACC_W
  localparam longint    RECIP_L = (longint'(1) << ACC_W) / TOTAL;
  localparam logic [MB_W-1:0] RECIP = MB_W'(RECIP_L);

  localparam logic [WT_W:0]     TWO_W    = (WT_W + 1)'(2 * WINDOW_LENGTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_FILL, S_WRITE, S_MAC,
    S_AVG_START, S_AVG_FIX, S_PCT, S_PCT_WAIT, S_DONE
  } state_t;

  // Configuration registers
  logic [SCALE_W-1:0] scale_r;
  logic [TICK_W-1:0]  interval_r;
  logic [MV_W-1:0]    vlow_r;
  logic [MV_W-1:0]    vhigh_r;
  logic [MV_W-1:0]    empty_r;
  logic [MV_W-1:0]    full_r;

  // Sequencer and block state
  state_t             state_r;
  logic [TICK_W-1:0]  ticks_r;
  logic               pending_r;
  logic               primed_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  fill_r;
  logic [AGE_W-1:0]   age_r;
  logic [MV_W-1:0]    last_valid_r;
  logic [MV_W-1:0]    smoothed_r;
  logic [RAW_W-1:0]   raw_r;
  logic               upd_r;
  logic               valid_r;
  logic [MV_W-1:0]    sample_r;
  logic [ACC_W-1:0]   acc_r;
  logic [MV_W-1:0]    avg_q_r;
  logic [PCT_W-1:0]   pct_r;

  logic               out_valid_r;
  logic [MV_W-1:0]    out_sm_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic               out_upd_r;
  logic               out_sv_r;

  // Datapath nets
  logic               in_fire;
  logic [TICK_W-1:0]  ticks_inc;
  logic               do_upd;
  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [PROD_W-1:0]  prod;
  logic [MVF_W-1:0]   mv_full;
  logic               in_win;
  logic [ACC_W-1:0]   avg_rem;
  logic [MV_W-1:0]    pct_d;
  logic [MV_W-1:0]    span;
  logic [WT_W:0]      wt_full;
  logic [WT_W-1:0]    weight;
  logic [SUM_W-1:0]   rd_sum;
  logic [SUM_W-1:0]   rd_mod;
  logic               ring_we;
  logic [SLOT_W-1:0]  ring_waddr;
  logic               ring_re;
  logic [SLOT_W-1:0]  ring_raddr;
  logic [MV_W-1:0]    ring_rdata;
  logic               out_free;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [DVD_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_fire        = in_chan.valid && (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_free       = !out_valid_r || out_chan.ready;

  assign ticks_inc = (ticks_r != '1) ? ticks_r + 1'b1 : ticks_r;
  assign do_upd    = pending_r || in_chan.force_update || (ticks_inc >= interval_r);

  // Shared multiplier: scaling, weighted sum, average, percent numerator
  always_comb begin
    case (state_r)
      S_MAC: begin
        mul_a = MA_W'(ring_rdata);
        mul_b = MB_W'(weight);
      end
      S_AVG_START: begin
        mul_a = MA_W'(acc_r);
        mul_b = RECIP;
      end
      S_AVG_FIX: begin
        mul_a = MA_W'(avg_q_r);
        mul_b = MB_W'(TOTAL);
      end
      S_PCT: begin
        mul_a = MA_W'(pct_d);
        mul_b = MB_W'(PCT_FULL);
      end
      default: begin
        mul_a = MA_W'(scale_r);
        mul_b = MB_W'(raw_r);
      end
    endcase
  end

  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign mv_full = prod[SCALE_SHIFT +: MVF_W];
  assign in_win  = (mv_full >= MVF_W'(vlow_r)) && (mv_full <= MVF_W'(vhigh_r));

  // The reciprocal estimate is the true quotient or one below it
  assign avg_rem = acc_r - prod[ACC_W-1:0];

  assign pct_d = smoothed_r - empty_r;
  assign span  = full_r - empty_r;

  // Weight of the entry read last cycle (age = age_r - 1)
  assign wt_full = TWO_W - (WT_W + 1)'(age_r);
  assign weight  = wt_full[WT_W-1:0];

  // Slot of age a is slot_r - 1 - a, modulo the window
  assign rd_sum = SUM_W'(slot_r) + SUM_W'(WINDOW_LENGTH - 1) - SUM_W'(age_r);
  assign rd_mod = (rd_sum >= SUM_W'(WINDOW_LENGTH)) ? rd_sum - SUM_W'(WINDOW_LENGTH) : rd_sum;

  assign ring_we    = (state_r == S_FILL) || (state_r == S_WRITE);
  assign ring_waddr = (state_r == S_FILL) ? fill_r : slot_r;
  assign ring_re    = (state_r == S_MAC) && (age_r < AGE_W'(WINDOW_LENGTH));
  assign ring_raddr = rd_mod[SLOT_W-1:0];

  bvs_ring #(
    .DEPTH  (WINDOW_LENGTH),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (sample_r),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  always_comb begin
    div_req.start = (state_r == S_PCT) && (full_r > empty_r) && (smoothed_r > empty_r)
                    && (pct_d < span);
    div_req.qbits = QBITS_PCT;
    div_dividend  = DVD_W'(prod);
    div_divisor   = DVS_W'(span);
  end

  bvs_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp)
  );

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= MV_SCALE_RST;
      interval_r <= INTERVAL_RST;
      vlow_r     <= VALID_LOW_RST;
      vhigh_r    <= VALID_HIGH_RST;
      empty_r    <= EMPTY_RST;
      full_r     <= FULL_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_idx_t'(cfg_chan.reg_index))
        CFG_MV_SCALE:   scale_r    <= cfg_chan.wdata[SCALE_W-1:0];
        CFG_INTERVAL:   interval_r <= cfg_chan.wdata[TICK_W-1:0];
        CFG_VALID_LOW:  vlow_r     <= cfg_chan.wdata[MV_W-1:0];
        CFG_VALID_HIGH: vhigh_r    <= cfg_chan.wdata[MV_W-1:0];
        CFG_EMPTY:      empty_r    <= cfg_chan.wdata[MV_W-1:0];
        CFG_FULL:       full_r     <= cfg_chan.wdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ticks_r      <= '0;
      pending_r    <= 1'b1;
      primed_r     <= 1'b0;
      slot_r       <= '0;
      last_valid_r <= '0;
      smoothed_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // drop valid once taken, unless a new result loads this cycle
      if (out_valid_r && out_chan.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            raw_r   <= in_chan.raw_sample;
            upd_r   <= do_upd;
            valid_r <= 1'b0;
            if (do_upd) begin
              ticks_r   <= '0;
              pending_r <= 1'b0;
              state_r   <= S_SCALE;
            end else begin
              ticks_r <= ticks_inc;
              state_r <= S_PCT;
            end
          end
        end
        S_SCALE: begin
          valid_r <= in_win;
          if (in_win) begin
            last_valid_r <= mv_full[MV_W-1:0];
            sample_r     <= mv_full[MV_W-1:0];
          end else begin
            sample_r <= last_valid_r;
          end
          fill_r  <= '0;
          state_r <= primed_r ? S_WRITE : S_FILL;
        end
        S_FILL: begin
          fill_r <= fill_r + 1'b1;
          if (fill_r == LAST_SLOT) begin
            primed_r <= 1'b1;
            state_r  <= S_WRITE;
          end
        end
        S_WRITE: begin
          slot_r  <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
          age_r   <= '0;
          acc_r   <= '0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          // accumulate the entry read last cycle, issue the next read
          if (age_r != '0) begin
            acc_r <= acc_r + prod[ACC_W-1:0];
          end
          age_r <= age_r + 1'b1;
          if (age_r == AGE_W'(WINDOW_LENGTH)) begin
            state_r <= S_AVG_START;
          end
        end
        S_AVG_START: begin
          avg_q_r <= prod[ACC_W +: MV_W];
          state_r <= S_AVG_FIX;
        end
        S_AVG_FIX: begin
          smoothed_r <= (avg_rem >= ACC_W'(TOTAL)) ? avg_q_r + 1'b1 : avg_q_r;
          state_r    <= S_PCT;
        end
        S_PCT: begin
          if (div_req.start) begin
            state_r <= S_PCT_WAIT;
          end else begin
            pct_r   <= ((full_r > empty_r) && (smoothed_r > empty_r)) ? PCT_FULL : '0;
            state_r <= S_DONE;
          end
        end
        S_PCT_WAIT: begin
          if (div_rsp.done) begin
            pct_r   <= div_rsp.quot[PCT_W-1:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_sm_r    <= smoothed_r;
            out_pct_r   <= pct_r;
            out_upd_r   <= upd_r;
            out_sv_r    <= valid_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.smoothed_mv    = out_sm_r;
  assign out_chan.charge_percent = out_pct_r;
  assign out_chan.updated        = out_upd_r;
  assign out_chan.sample_valid   = out_sv_r;

  a_valid_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (!out_chan.sample_valid || out_chan.updated))
    else $error("sample_valid set on a beat without an update");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.charge_percent <= PCT_FULL))
    else $error("charge_percent above full scale");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken while an item is in flight");

  a_walk_after_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (primed_r && !div_rsp.busy))
    else $error("ring walk before priming or with divider busy");

endmodule

`default_nettype wire

// ===== rtl/bvs_ring.sv =====
// Sample ring memory: one write port, one registered read port.
// Depends on bvs_pkg for the sample width.
`default_nettype none

module bvs_ring #(
  parameter int DEPTH  = bvs_pkg::WINDOW_LENGTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [ADDR_W-1:0]       waddr,
  input  wire logic [bvs_pkg::MV_W-1:0] wdata,
  input  wire logic                    re,
  input  wire logic [ADDR_W-1:0]       raddr,
  output      logic [bvs_pkg::MV_W-1:0] rdata
);
  import bvs_pkg::*;

  logic [MV_W-1:0] mem [DEPTH];
  logic [MV_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/bvs_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient up to MV_W bits.
// Depends on bvs_pkg for the request and response structs.
`default_nettype none

module bvs_div #(
  parameter int DVD_W = 26,
  parameter int DVS_W = bvs_pkg::MV_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bvs_pkg::div_req_t req,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [DVS_W-1:0]  divisor,
  output      bvs_pkg::div_rsp_t rsp
);
  import bvs_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_QCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]      rem_r;
  logic [DVD_W-1:0]      dsh_r;
  logic [MV_W-1:0]       quot_r;
  logic                  fits;

  // Caller guarantees dividend < divisor << qbits
  assign fits = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.qbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_QCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= dividend;
      dsh_r  <= DVD_W'(divisor) << (req.qbits - 1'b1);
      quot_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quot_r <= {quot_r[MV_W-2:0], fits};
      dsh_r  <= dsh_r >> 1;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

// ===== bench/bvs_smoother_ledger_pkg.sv =====
// Scoreboard for the battery voltage smoother bench: tracks the register
// settings and ring state, predicts each result beat and checks the DUT's.
// Depends on bvs_pkg for widths, reset values and register indexes.
package bvs_smoother_ledger_pkg;
  import bvs_pkg::*;

  localparam int WIN        = WINDOW_LENGTH_DEF;
  localparam int WEIGHT_SUM = WIN * (3 * WIN - 1) / 2;

  typedef struct {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    logic             upd;
    logic             in_window;
  } reading_t;

  class smoothed_reading_ledger;
    reading_t awaited_readings[$];
    int unsigned err_count;

    logic [SCALE_W-1:0] scale_q16;
    logic [TICK_W-1:0]  interval;
    logic [MV_W-1:0]    win_lo;
    logic [MV_W-1:0]    win_hi;
    logic [MV_W-1:0]    empty_lvl;
    logic [MV_W-1:0]    full_lvl;

    logic [MV_W-1:0]    ring[WIN];
    int unsigned        slot;
    bit                 primed;
    logic [MV_W-1:0]    held_mv;
    logic [MV_W-1:0]    avg_mv;
    logic [TICK_W-1:0]  idle_ticks;
    bit                 first_due;

    function new();
      scale_q16  = MV_SCALE_RST;
      interval   = INTERVAL_RST;
      win_lo     = VALID_LOW_RST;
      win_hi     = VALID_HIGH_RST;
      empty_lvl  = EMPTY_RST;
      full_lvl   = FULL_RST;
      foreach (ring[i]) ring[i] = '0;
      slot       = 0;
      primed     = 0;
      held_mv    = '0;
      avg_mv     = '0;
      idle_ticks = '0;
      first_due  = 1;
      err_count  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (cfg_idx_t'(idx))
        CFG_MV_SCALE:   scale_q16 = data[SCALE_W-1:0];
        CFG_INTERVAL:   interval  = data[TICK_W-1:0];
        CFG_VALID_LOW:  win_lo    = data[MV_W-1:0];
        CFG_VALID_HIGH: win_hi    = data[MV_W-1:0];
        CFG_EMPTY:      empty_lvl = data[MV_W-1:0];
        CFG_FULL:       full_lvl  = data[MV_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PCT_W-1:0] percent_of(logic [MV_W-1:0] mv);
      logic [31:0] pct;
      if (full_lvl <= empty_lvl || mv <= empty_lvl) return '0;
      pct = (32'(mv - empty_lvl) * 32'(PCT_FULL)) / 32'(full_lvl - empty_lvl);
      return (pct > 32'(PCT_FULL)) ? PCT_FULL : PCT_W'(pct);
    endfunction

    // One accepted sample beat is one tick of the smoother.
    function void take_sample(logic [RAW_W-1:0] raw, logic frc);
      reading_t    r;
      logic [63:0] scaled;
      logic [63:0] acc;
      bit          upd;
      bit          ok;
      int unsigned age;
      int unsigned pos;
      if (idle_ticks != {TICK_W{1'b1}}) idle_ticks++;
      upd = first_due || frc || idle_ticks >= interval;
      ok  = 0;
      if (upd) begin
        scaled = (64'(raw) * 64'(scale_q16)) >> SCALE_SHIFT;
        ok = scaled >= 64'(win_lo) && scaled <= 64'(win_hi);
        if (ok) held_mv = scaled[MV_W-1:0];
        if (!primed) begin
          foreach (ring[i]) ring[i] = held_mv;
          primed = 1;
        end
        ring[slot] = held_mv;
        slot = (slot + 1) % WIN;
        // newest entry weighs 2*WIN-1, oldest weighs WIN
        acc = '0;
        for (age = 0; age < WIN; age++) begin
          pos = (slot + WIN - 1 - age) % WIN;
          acc += 64'(ring[pos]) * 64'(2 * WIN - 1 - age);
        end
        avg_mv     = MV_W'(acc / WEIGHT_SUM);
        idle_ticks = '0;
        first_due  = 0;
      end
      r.mv        = avg_mv;
      r.pct       = percent_of(avg_mv);
      r.upd       = upd;
      r.in_window = ok;
      awaited_readings.push_back(r);
    endfunction

    function void match_reading(logic [MV_W-1:0] mv, logic [PCT_W-1:0] pct,
                                logic upd, logic in_window);
      reading_t want;
      if (awaited_readings.size() == 0) begin
        $error("result beat with nothing awaited: smoothed_mv=%0d", mv);
        err_count++;
        return;
      end
      want = awaited_readings.pop_front();
      if (mv !== want.mv) begin
        $error("smoothed_mv: expected %0d, got %0d", want.mv, mv);
        err_count++;
      end
      if (pct !== want.pct) begin
        $error("charge_percent: expected %0d, got %0d", want.pct, pct);
        err_count++;
      end
      if (upd !== want.upd) begin
        $error("updated: expected %0d, got %0d", want.upd, upd);
        err_count++;
      end
      if (in_window !== want.in_window) begin
        $error("sample_valid: expected %0d, got %0d", want.in_window, in_window);
        err_count++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited_readings.size();
    endfunction
  endclass

endpackage

// ===== bench/battery_voltage_smoother_unit_tb.sv =====
// Top-level bench for battery_voltage_smoother_unit: directed corner ticks,
// then randomized register settings and samples under varying back-pressure.
// Depends on bvs_pkg, the bvs_*_if interfaces and bvs_smoother_ledger_pkg.
module battery_voltage_smoother_unit_tb;
  import bvs_pkg::*;
  import bvs_smoother_ledger_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned SEGMENTS = 20;
  localparam int unsigned SEG_ITEMS = 70;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;
  int unsigned cycle_count;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  bvs_in_if  in_ch();
  bvs_out_if out_ch();
  bvs_cfg_if cfg_ch();

  smoothed_reading_ledger ledger = new();

  battery_voltage_smoother_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      ledger.match_reading(out_ch.smoothed_mv, out_ch.charge_percent,
                           out_ch.updated, out_ch.sample_valid);
  end

  // Leave valid high between back-to-back beats; drop it only in a gap.
  task automatic send_sample(input logic [RAW_W-1:0] raw, input logic frc);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.raw_sample   <= raw;
    in_ch.force_update <= frc;
    do @(posedge clk); while (!in_ch.ready);
    ledger.take_sample(raw, frc);
  endtask

  task automatic hold_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (ledger.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    ledger.set_reg(idx, data);
  endtask

  task automatic program_config(input logic [CFG_DATA_W-1:0] scale,
                                input logic [CFG_DATA_W-1:0] ticks,
                                input logic [CFG_DATA_W-1:0] lo,
                                input logic [CFG_DATA_W-1:0] hi,
                                input logic [CFG_DATA_W-1:0] empty_lvl,
                                input logic [CFG_DATA_W-1:0] full_lvl,
                                input bit with_spares);
    write_reg(CFG_MV_SCALE, scale);
    write_reg(CFG_INTERVAL, ticks);
    write_reg(CFG_VALID_LOW, lo);
    write_reg(CFG_VALID_HIGH, hi);
    write_reg(CFG_EMPTY, empty_lvl);
    write_reg(CFG_FULL, full_lvl);
    if (with_spares) begin
      // unmapped indexes must not touch any register
      write_reg(CFG_SPARE_LO, {CFG_DATA_W{1'b1}});
      write_reg(CFG_SPARE_HI, 24'h5a5a5a);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_config();
    int unsigned scale;
    int unsigned ticks;
    int unsigned lo;
    int unsigned hi;
    int unsigned e_lvl;
    int unsigned f_lvl;
    scale = ($urandom_range(3) == 0) ? $urandom_range(1048575) : $urandom_range(60000, 160000);
    case ($urandom_range(7))
      0, 1, 2, 3: ticks = $urandom_range(6);
      4, 5:       ticks = $urandom_range(7, 40);
      6:          ticks = 0;
      default:    ticks = $urandom_range(16777215);
    endcase
    if ($urandom_range(7) == 0) begin
      hi = $urandom_range(4000);
      lo = $urandom_range(hi + 1, 8191);
    end else begin
      lo = $urandom_range(4000);
      hi = $urandom_range(lo, 8191);
    end
    if ($urandom_range(7) == 0) begin
      f_lvl = $urandom_range(5000);
      e_lvl = $urandom_range(f_lvl, 8191);
    end else begin
      e_lvl = $urandom_range(5000);
      f_lvl = $urandom_range(e_lvl + 1, 8191);
    end
    program_config(CFG_DATA_W'(scale), CFG_DATA_W'(ticks), CFG_DATA_W'(lo),
                   CFG_DATA_W'(hi), CFG_DATA_W'(e_lvl), CFG_DATA_W'(f_lvl), 1'b0);
  endtask

  // Mostly aim the scaled value inside the window; the rest is raw noise.
  function automatic logic [RAW_W-1:0] pick_raw();
    logic [63:0] target;
    logic [63:0] code;
    if (ledger.scale_q16 == 0 || ledger.win_lo > ledger.win_hi || $urandom_range(9) < 3)
      return RAW_W'($urandom_range(4095));
    target = 64'($urandom_range(ledger.win_lo, ledger.win_hi));
    code = (target << SCALE_SHIFT) / ledger.scale_q16;
    return (code > 4095) ? RAW_W'(4095) : RAW_W'(code);
  endfunction

  initial begin
    int unsigned seg;
    int unsigned n;
    cycle_count        = 0;
    send_gap_pct       = 0;
    recv_stall_pct     = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.raw_sample   <= '0;
    in_ch.force_update <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.reg_index   <= '0;
    cfg_ch.wdata       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: first tick primes the ring with an invalid (zero) sample
    send_sample(12'd0, 1'b0);
    send_sample(12'd2000, 1'b0);
    send_sample(12'd2000, 1'b1);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd2607, 1'b1);
    send_sample(12'd1551, 1'b1);
    send_sample(12'd1552, 1'b1);
    send_sample(12'd3103, 1'b1);
    send_sample(12'd3104, 1'b1);
    send_sample(12'd100, 1'b0);
    hold_input();
    wait_drained();

    // Widest window, largest scale, update on every tick
    program_config(24'hfffff, 24'd0, 24'd0, 24'd8191, 24'd0, 24'd8191, 1'b1);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd1, 1'b0);
    send_sample(12'd546, 1'b0);
    send_sample(12'd511, 1'b1);
    send_sample(12'd2048, 1'b0);
    hold_input();
    wait_drained();

    // Zero scale, empty window, full below empty, interval of one
    program_config(24'd0, 24'd1, 24'd5000, 24'd2000, 24'd4200, 24'd3200, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b1);
    send_sample(12'd1234, 1'b0);
    hold_input();
    wait_drained();

    // Longest interval, full equal to empty
    program_config(24'd105600, 24'hffffff, 24'd2500, 24'd5000, 24'd3000, 24'd3000, 1'b0);
    send_sample(12'd2500, 1'b1);
    send_sample(12'd100, 1'b0);
    send_sample(12'd2222, 1'b0);
    send_sample(12'd2900, 1'b1);
    hold_input();
    wait_drained();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / (SEGMENTS / 4))
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_gap_pct = 82; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 82; end
        default: begin send_gap_pct = 13; recv_stall_pct = 13; end
      endcase
      random_config();
      for (n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(149) == 0) begin
          hold_input();
          wait_drained();
        end
        send_sample(pick_raw(), $urandom_range(99) < 30);
      end
      hold_input();
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.err_count == 0 && ledger.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
